// ===== design/tlbf_pkg.sv =====
// Package: sizes, mode codes, controller state and command types for the TLB core.
package tlbf_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int VPN_BITS = 20;
	localparam int PPN_BITS = 22;
	localparam int FLG_W    = 8;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== design/tlbf_ctrl.sv =====
// Controller: accepts one transfer, runs it through the datapath, owns output valid.
module tlbf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tlbf_pkg::dp_cmd_t cmd
);
	import tlbf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_ready && in_valid;
	assign cmd.exec  = (state_q == ST_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/tlbf_dp.sv =====
// Datapath: entry storage, parallel tag compare, FIFO replacement pointer, result register.
module tlbf_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlbf_pkg::dp_cmd_t              cmd,
	input  logic [tlbf_pkg::MODE_W-1:0]    mode,
	input  logic [tlbf_pkg::VPN_BITS-1:0]  vpn,
	input  logic [tlbf_pkg::PPN_BITS-1:0]  ppn,
	input  logic [tlbf_pkg::FLG_W-1:0]     flags,
	output logic                           hit,
	output logic [tlbf_pkg::PPN_BITS-1:0]  frame_out,
	output logic [tlbf_pkg::FLG_W-1:0]     flags_out
);
	import tlbf_pkg::*;

	// held request
	logic [MODE_W-1:0]   mode_q;
	logic [VPN_BITS-1:0] vpn_q;
	logic [PPN_BITS-1:0] ppn_q;
	logic [FLG_W-1:0]    flags_q;

	// entries; valid entries always form a prefix of fill_q entries
	logic [VPN_BITS-1:0] tag_q   [ENTRIES];
	logic [PPN_BITS-1:0] frame_q [ENTRIES];
	logic [FLG_W-1:0]    prot_q  [ENTRIES];
	logic [CNT_W-1:0]    fill_q;
	logic [IDX_W-1:0]    head_q;

	logic                hit_q;
	logic [PPN_BITS-1:0] frame_out_q;
	logic [FLG_W-1:0]    flags_out_q;

	logic [ENTRIES-1:0]  match;
	logic                lk_hit;
	logic [PPN_BITS-1:0] lk_frame;
	logic [FLG_W-1:0]    lk_prot;
	logic                full;
	logic [IDX_W-1:0]    target;

	assign full   = (fill_q == CNT_W'(ENTRIES));
	assign target = full ? head_q : fill_q[IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (CNT_W'(i) < fill_q) && (tag_q[i] == vpn_q);
		end
	end

	// lowest index wins
	always_comb begin
		lk_hit   = 1'b0;
		lk_frame = '0;
		lk_prot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				lk_hit   = 1'b1;
				lk_frame = frame_q[i];
				lk_prot  = prot_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			vpn_q   <= vpn;
			ppn_q   <= ppn;
			flags_q <= flags;
		end
		if (cmd.exec && mode_q == MODE_INSERT) begin
			tag_q[target]   <= vpn_q;
			frame_q[target] <= ppn_q;
			prot_q[target]  <= flags_q;
		end
		if (cmd.exec) begin
			if (mode_q == MODE_LOOKUP) begin
				hit_q       <= lk_hit;
				frame_out_q <= lk_frame;
				flags_out_q <= lk_prot;
			end else begin
				hit_q       <= 1'b0;
				frame_out_q <= '0;
				flags_out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
		end else if (cmd.exec) begin
			if (mode_q == MODE_FLUSH) begin
				fill_q <= '0;
				head_q <= '0;
			end else if (mode_q == MODE_INSERT) begin
				if (!full) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (head_q == IDX_W'(ENTRIES - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + IDX_W'(1);
				end
			end
		end
	end

	assign hit       = hit_q;
	assign frame_out = frame_out_q;
	assign flags_out = flags_out_q;

endmodule

// ===== design/fully_assoc_tlb_fifo_replace_core.sv =====
// Top level: fully associative TLB with FIFO replacement, controller plus datapath.
// Each accepted transfer (lookup, insert or flush) has two steps: the request is
// captured, then all 16 tags are compared in parallel and the entry array, fill count
// and replacement pointer are updated; no new request is taken before that update. The
// result sits in an output register, and the next request is taken while it waits; a
// request finishes only once that register is free. Insert fills the lowest free entry
// and, once all are valid, overwrites the oldest one in fill order.
module fully_assoc_tlb_fifo_replace_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tlbf_pkg::MODE_W-1:0]    mode,
	input  logic [tlbf_pkg::VPN_BITS-1:0]  vpn,
	input  logic [tlbf_pkg::PPN_BITS-1:0]  ppn,
	input  logic [tlbf_pkg::FLG_W-1:0]     flags,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [tlbf_pkg::PPN_BITS-1:0]  frame_out,
	output logic [tlbf_pkg::FLG_W-1:0]     flags_out
);
	import tlbf_pkg::*;

	dp_cmd_t cmd;

	tlbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tlbf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode),
		.vpn       (vpn),
		.ppn       (ppn),
		.flags     (flags),
		.hit       (hit),
		.frame_out (frame_out),
		.flags_out (flags_out)
	);

endmodule

// ===== tb/sv/fully_assoc_tlb_fifo_replace_core_test.sv =====
// Testbench for the FIFO-replacement TLB core: directed and random traffic checked against a predictor.
module fully_assoc_tlb_fifo_replace_core_test;
	import tlbf_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef logic [VPN_BITS-1:0] vpn_t;
	typedef logic [PPN_BITS-1:0] ppn_t;
	typedef logic [FLG_W-1:0]    flg_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef struct packed {
		logic hit;
		ppn_t frame;
		flg_t prot;
	} xlate_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [MODE_W-1:0] mode = MODE_LOOKUP;
	vpn_t              vpn = '0;
	ppn_t              ppn = '0;
	flg_t              flags = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              hit;
	ppn_t              frame_out;
	flg_t              flags_out;

	logic  tlb_valid [ENTRIES];
	vpn_t  tlb_tag   [ENTRIES];
	ppn_t  tlb_frame [ENTRIES];
	flg_t  tlb_prot  [ENTRIES];
	idx_t  fill_order [$];

	xlate_t expected_xlates [$];
	int     errors = 0;
	bit     idle_en = 1'b1;
	int     stall_left = 0;

	fully_assoc_tlb_fifo_replace_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.vpn       (vpn),
		.ppn       (ppn),
		.flags     (flags),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.frame_out (frame_out),
		.flags_out (flags_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic xlate_t translate(logic [MODE_W-1:0] m, vpn_t v, ppn_t p, flg_t f);
		xlate_t res;
		bit     found;
		idx_t   tgt;
		res = '0;
		found = 1'b0;
		tgt = '0;
		case (m)
			MODE_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++)
					if (!found && tlb_valid[i] && tlb_tag[i] == v) begin
						found = 1'b1;
						res.hit = 1'b1;
						res.frame = tlb_frame[i];
						res.prot = tlb_prot[i];
					end
			end
			MODE_INSERT: begin
				for (int i = 0; i < ENTRIES; i++)
					if (!found && !tlb_valid[i]) begin
						found = 1'b1;
						tgt = idx_t'(i);
					end
				if (!found)
					tgt = fill_order.pop_front();
				fill_order.push_back(tgt);
				tlb_valid[tgt] = 1'b1;
				tlb_tag[tgt] = v;
				tlb_frame[tgt] = p;
				tlb_prot[tgt] = f;
			end
			MODE_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++)
					tlb_valid[i] = 1'b0;
				fill_order.delete();
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_error(string what, xlate_t want, xlate_t got);
		if (errors < 10)
			$display("%0t: %s: expected hit=%0b frame=%h flags=%h, got hit=%0b frame=%h flags=%h",
				$time, what, want.hit, want.frame, want.prot, got.hit, got.frame, got.prot);
		errors++;
	endtask

	// One request transfer; an optional idle burst goes ahead of it.
	task automatic send_req(logic [MODE_W-1:0] m, vpn_t v, ppn_t p, flg_t f);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		vpn <= v;
		ppn <= p;
		flags <= f;
		do @(posedge clk); while (!in_ready);
		expected_xlates.push_back(translate(m, v, p, f));
	endtask

	task automatic wait_drained();
		while (expected_xlates.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!idle_en)
			out_ready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		xlate_t got;
		xlate_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{hit, frame_out, flags_out};
			if (expected_xlates.size() == 0)
				report_error("unexpected transfer", '0, got);
			else begin
				want = expected_xlates.pop_front();
				if (got.hit !== want.hit || got.frame !== want.frame || got.prot !== want.prot)
					report_error("result mismatch", want, got);
			end
		end
	end

	task automatic test_basic_ops();
		send_req(MODE_LOOKUP, '0, '0, '0);
		send_req(MODE_INSERT, '0, '1, '1);
		send_req(MODE_INSERT, '1, '0, '0);
		send_req(MODE_LOOKUP, '0, '0, '0);
		send_req(MODE_LOOKUP, '1, '1, '1);
		send_req(MODE_INSERT, 20'h5A5A5, 22'h2AAAAA, 8'h55);
		// duplicate tag: lowest index must win
		send_req(MODE_INSERT, 20'h5A5A5, 22'h155555, 8'hAA);
		send_req(MODE_LOOKUP, 20'h5A5A5, '0, '0);
		send_req(MODE_LOOKUP, 20'hA5A5A, 22'h155555, 8'hAA);
		send_req(MODE_UNUSED, '1, '1, '1);
		send_req(MODE_LOOKUP, '1, '0, '0);
		send_req(MODE_FLUSH, '1, '1, '1);
		send_req(MODE_LOOKUP, '0, '0, '0);
		send_req(MODE_LOOKUP, '1, '0, '0);
		send_req(MODE_INSERT, '1, 22'h3C3C3C, 8'hC3);
		send_req(MODE_LOOKUP, '1, '0, '0);
	endtask

	task automatic test_fifo_replace();
		send_req(MODE_FLUSH, '0, '0, '0);
		for (int i = 0; i < ENTRIES + 3; i++)
			send_req(MODE_INSERT, vpn_t'(20'h10000 + i), ppn_t'(i * 977), flg_t'(i));
		send_req(MODE_LOOKUP, vpn_t'(20'h10000), '0, '0);
		send_req(MODE_LOOKUP, vpn_t'(20'h10003), '0, '0);
		send_req(MODE_LOOKUP, vpn_t'(20'h10012), '0, '0);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_req(MODE_INSERT, vpn_t'($urandom), ppn_t'($urandom), flg_t'($urandom));
		in_valid <= 1'b0;
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_req(MODE_LOOKUP, vpn_t'($urandom), '0, '0);
	endtask

	// Episodes: flush, then mostly inserts and lookups over a small tag pool, with some
	// random lookups, unused modes and flushes, so hits, duplicates and FIFO evictions all occur.
	task automatic test_random_traffic(int n_items);
		vpn_t pool [20];
		int   sent;
		int   ep_len;
		int   r;
		sent = 0;
		while (sent < n_items) begin
			foreach (pool[k])
				pool[k] = vpn_t'($urandom);
			send_req(MODE_FLUSH, vpn_t'($urandom), ppn_t'($urandom), flg_t'($urandom));
			ep_len = $urandom_range(30, 60);
			repeat (ep_len) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					send_req(MODE_INSERT, pool[$urandom_range(0, 19)], ppn_t'($urandom),
						flg_t'($urandom));
				else if (r < 88)
					send_req(MODE_LOOKUP, pool[$urandom_range(0, 19)], ppn_t'($urandom),
						flg_t'($urandom));
				else if (r < 94)
					send_req(MODE_LOOKUP, vpn_t'($urandom), ppn_t'($urandom), flg_t'($urandom));
				else if (r < 98)
					send_req(MODE_UNUSED, vpn_t'($urandom), ppn_t'($urandom), flg_t'($urandom));
				else
					send_req(MODE_FLUSH, vpn_t'($urandom), ppn_t'($urandom), flg_t'($urandom));
			end
			sent += ep_len + 1;
		end
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int i = 0; i < 20; i++)
			send_req(MODE_INSERT, vpn_t'(i), ppn_t'($urandom), flg_t'($urandom));
		for (int i = 0; i < 24; i++)
			send_req(MODE_LOOKUP, vpn_t'($urandom_range(0, 23)), '0, '0);
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_tag[i] = '0;
			tlb_frame[i] = '0;
			tlb_prot[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_fifo_replace();
		test_drain_pause();
		test_random_traffic(340);
		test_back_to_back();
		in_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_xlates.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
